// ----- rtl/gdpd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdpd_pkg
// Types, constants and helpers shared by the densify/prune decider.
// ----------------------------------------------------------------------------
`default_nettype none

package gdpd_pkg;

    localparam int GRAD_W   = 32;
    localparam int CNT_W    = 16;
    localparam int LOG_W    = 24;
    localparam int RAD_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int PROD_W   = GRAD_W + CNT_W;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // round(log(1.6) * 2^16)
    localparam logic signed [LOG_W-1:0] SPLIT_SHIFT = 24'sd30802;
    localparam logic signed [LOG_W-1:0] LOG_MIN     = 24'sh800000;

    localparam logic [GRAD_W-1:0]       RST_GRAD_LIMIT        = 32'd3355;
    localparam logic signed [LOG_W-1:0] RST_LOG_DENSE_SIZE    = -24'sd301802;
    localparam logic signed [LOG_W-1:0] RST_LOG_PRUNE_SIZE    = -24'sd150902;
    localparam logic signed [LOG_W-1:0] RST_MIN_OPACITY_LOGIT = -24'sd346880;
    localparam logic [RAD_W-1:0]        RST_MAX_SCREEN_RADIUS = 12'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAD_LIMIT        = 3'd0,
        CFG_LOG_DENSE_SIZE    = 3'd1,
        CFG_LOG_PRUNE_SIZE    = 3'd2,
        CFG_MIN_OPACITY_LOGIT = 3'd3,
        CFG_MAX_SCREEN_RADIUS = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_KEEP  = 2'd0,
        ACT_CLONE = 2'd1,
        ACT_SPLIT = 2'd2
    } t_action;

    typedef struct packed {
        logic [GRAD_W-1:0]       grad_limit;
        logic signed [LOG_W-1:0] log_dense_size;
        logic signed [LOG_W-1:0] log_prune_size;
        logic signed [LOG_W-1:0] min_opacity_logit;
        logic [RAD_W-1:0]        max_screen_radius;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        t_action                 action;
        logic                    original_kept;
        logic                    clone_kept;
        logic                    op_low;
        logic signed [LOG_W-1:0] sx;
        logic signed [LOG_W-1:0] sy;
        logic signed [LOG_W-1:0] sz;
    } t_cls;

    function automatic logic signed [LOG_W-1:0] max3(
        input logic signed [LOG_W-1:0] a,
        input logic signed [LOG_W-1:0] b,
        input logic signed [LOG_W-1:0] c
    );
        logic signed [LOG_W-1:0] m;
        m = ($signed(a) > $signed(b)) ? a : b;
        return ($signed(m) > $signed(c)) ? m : c;
    endfunction

    // subtract the split shift, saturating at the most negative code
    function automatic logic signed [LOG_W-1:0] shrink(input logic signed [LOG_W-1:0] v);
        logic signed [LOG_W:0] d;
        d = $signed({v[LOG_W-1], v}) - $signed({SPLIT_SHIFT[LOG_W-1], SPLIT_SHIFT});
        if (d < $signed({LOG_MIN[LOG_W-1], LOG_MIN})) begin
            return LOG_MIN;
        end
        return d[LOG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gdpd_ifs.sv -----
// ----------------------------------------------------------------------------
// gdpd interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdpd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [gdpd_pkg::GRAD_W-1:0]           grad_sum;
    logic [gdpd_pkg::CNT_W-1:0]            view_count;
    logic signed [gdpd_pkg::LOG_W-1:0]     log_scale_x;
    logic signed [gdpd_pkg::LOG_W-1:0]     log_scale_y;
    logic signed [gdpd_pkg::LOG_W-1:0]     log_scale_z;
    logic signed [gdpd_pkg::LOG_W-1:0]     opacity_logit;
    logic [gdpd_pkg::RAD_W-1:0]            max_radius;

    modport source (output valid, output grad_sum, output view_count,
                    output log_scale_x, output log_scale_y, output log_scale_z,
                    output opacity_logit, output max_radius, input ready);
    modport sink   (input valid, input grad_sum, input view_count,
                    input log_scale_x, input log_scale_y, input log_scale_z,
                    input opacity_logit, input max_radius, output ready);
endinterface

interface gdpd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            action;
    logic                                  original_kept;
    logic [1:0]                            new_kept;
    logic signed [gdpd_pkg::LOG_W-1:0]     child_log_scale_x;
    logic signed [gdpd_pkg::LOG_W-1:0]     child_log_scale_y;
    logic signed [gdpd_pkg::LOG_W-1:0]     child_log_scale_z;

    modport source (output valid, output action, output original_kept, output new_kept,
                    output child_log_scale_x, output child_log_scale_y,
                    output child_log_scale_z, input ready);
    modport sink   (input valid, input action, input original_kept, input new_kept,
                    input child_log_scale_x, input child_log_scale_y,
                    input child_log_scale_z, output ready);
endinterface

interface gdpd_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [gdpd_pkg::CFG_IDX_W-1:0]        index;
    logic [gdpd_pkg::CFG_DAT_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gdpd_front.sv -----
// ----------------------------------------------------------------------------
// gdpd_front
// Accepts requests, forms threshold*count and the largest log scale, and
// classifies each request as keep, clone or split with its prune flags.
// ----------------------------------------------------------------------------
`default_nettype none

module gdpd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gdpd_pkg::t_cfg i_cfg,
    gdpd_in_if.sink             i_in,
    output logic                o_push_valid,
    input  wire logic           i_push_ready,
    output gdpd_pkg::t_cls      o_push_data
);

    typedef struct packed {
        logic [gdpd_pkg::GRAD_W-1:0]       grad_sum;
        logic [gdpd_pkg::CNT_W-1:0]        view_count;
        logic signed [gdpd_pkg::LOG_W-1:0] sx;
        logic signed [gdpd_pkg::LOG_W-1:0] sy;
        logic signed [gdpd_pkg::LOG_W-1:0] sz;
        logic signed [gdpd_pkg::LOG_W-1:0] op;
        logic [gdpd_pkg::RAD_W-1:0]        rad;
    } t_s0;

    typedef struct packed {
        logic [gdpd_pkg::GRAD_W-1:0]       grad_sum;
        logic                              cnt_zero;
        logic [gdpd_pkg::PROD_W-1:0]       prod;
        logic signed [gdpd_pkg::LOG_W-1:0] m;
        logic                              op_low;
        logic                              rad_big;
        logic signed [gdpd_pkg::LOG_W-1:0] sx;
        logic signed [gdpd_pkg::LOG_W-1:0] sy;
        logic signed [gdpd_pkg::LOG_W-1:0] sz;
    } t_s1;

    logic r_v0, r_v1;
    t_s0  r_s0, n_s0;
    t_s1  r_s1, n_s1;
    logic w_s0_ready, w_s1_ready;

    logic w_densify, w_split, w_too_big;

    assign w_s1_ready = !r_v1 || i_push_ready;
    assign w_s0_ready = !r_v0 || w_s1_ready;
    assign i_in.ready = w_s0_ready;

    always_comb begin
        n_s0.grad_sum   = i_in.grad_sum;
        n_s0.view_count = i_in.view_count;
        n_s0.sx         = i_in.log_scale_x;
        n_s0.sy         = i_in.log_scale_y;
        n_s0.sz         = i_in.log_scale_z;
        n_s0.op         = i_in.opacity_logit;
        n_s0.rad        = i_in.max_radius;
    end

    always_comb begin
        n_s1.grad_sum = r_s0.grad_sum;
        n_s1.cnt_zero = (r_s0.view_count == '0);
        n_s1.prod     = i_cfg.grad_limit * r_s0.view_count;
        n_s1.m        = gdpd_pkg::max3(r_s0.sx, r_s0.sy, r_s0.sz);
        n_s1.op_low   = $signed(r_s0.op) < $signed(i_cfg.min_opacity_logit);
        n_s1.rad_big  = r_s0.rad > i_cfg.max_screen_radius;
        n_s1.sx       = r_s0.sx;
        n_s1.sy       = r_s0.sy;
        n_s1.sz       = r_s0.sz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_s0_ready) begin
                r_v0 <= i_in.valid;
            end
            if (w_s1_ready) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_ready && i_in.valid) begin
            r_s0 <= n_s0;
        end
        if (w_s1_ready && r_v0) begin
            r_s1 <= n_s1;
        end
    end

    // zero views: average counts as zero
    assign w_densify = r_s1.cnt_zero ? (i_cfg.grad_limit == '0)
                     : ({{gdpd_pkg::CNT_W{1'b0}}, r_s1.grad_sum} >= r_s1.prod);
    assign w_split   = w_densify && ($signed(r_s1.m) > $signed(i_cfg.log_dense_size));
    assign w_too_big = $signed(r_s1.m) > $signed(i_cfg.log_prune_size);

    always_comb begin
        priority if (w_split) begin
            o_push_data.action = gdpd_pkg::ACT_SPLIT;
        end else if (w_densify) begin
            o_push_data.action = gdpd_pkg::ACT_CLONE;
        end else begin
            o_push_data.action = gdpd_pkg::ACT_KEEP;
        end
        o_push_data.original_kept = !w_split && !r_s1.op_low && !w_too_big && !r_s1.rad_big;
        o_push_data.clone_kept    = !r_s1.op_low && !w_too_big;
        o_push_data.op_low        = r_s1.op_low;
        o_push_data.sx            = r_s1.sx;
        o_push_data.sy            = r_s1.sy;
        o_push_data.sz            = r_s1.sz;
    end

    assign o_push_valid = r_v1;

endmodule

`default_nettype wire

// ----- rtl/gdpd_queue.sv -----
// ----------------------------------------------------------------------------
// gdpd_queue
// Small register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gdpd_queue #(
    parameter int DEPTH = gdpd_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire gdpd_pkg::t_cls i_push_data,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output gdpd_pkg::t_cls      o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    gdpd_pkg::t_cls   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gdpd_back.sv -----
// ----------------------------------------------------------------------------
// gdpd_back
// Carries out the decision: child scales, child prune test and the result
// register toward the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module gdpd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gdpd_pkg::t_cfg i_cfg,
    input  wire logic           i_pop_valid,
    output logic                o_pop_ready,
    input  wire gdpd_pkg::t_cls i_pop_data,
    gdpd_out_if.source          o_out
);

    typedef struct packed {
        gdpd_pkg::t_action                 action;
        logic                              original_kept;
        logic [1:0]                        new_kept;
        logic signed [gdpd_pkg::LOG_W-1:0] cx;
        logic signed [gdpd_pkg::LOG_W-1:0] cy;
        logic signed [gdpd_pkg::LOG_W-1:0] cz;
    } t_res;

    logic r_ov;
    t_res r_res, n_res;
    logic signed [gdpd_pkg::LOG_W-1:0] w_hx, w_hy, w_hz, w_hm;

    assign o_pop_ready = !r_ov || o_out.ready;

    assign w_hx = gdpd_pkg::shrink(i_pop_data.sx);
    assign w_hy = gdpd_pkg::shrink(i_pop_data.sy);
    assign w_hz = gdpd_pkg::shrink(i_pop_data.sz);
    assign w_hm = gdpd_pkg::max3(w_hx, w_hy, w_hz);

    always_comb begin
        n_res.action        = i_pop_data.action;
        n_res.original_kept = i_pop_data.original_kept;
        unique case (i_pop_data.action)
            gdpd_pkg::ACT_SPLIT: begin
                n_res.cx = w_hx;
                n_res.cy = w_hy;
                n_res.cz = w_hz;
                n_res.new_kept = (!i_pop_data.op_low &&
                                  !($signed(w_hm) > $signed(i_cfg.log_prune_size)))
                               ? 2'd2 : 2'd0;
            end
            gdpd_pkg::ACT_CLONE: begin
                n_res.cx = i_pop_data.sx;
                n_res.cy = i_pop_data.sy;
                n_res.cz = i_pop_data.sz;
                n_res.new_kept = i_pop_data.clone_kept ? 2'd1 : 2'd0;
            end
            default: begin
                n_res.cx = '0;
                n_res.cy = '0;
                n_res.cz = '0;
                n_res.new_kept = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop_ready) begin
            r_ov <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.action            = r_res.action;
    assign o_out.original_kept     = r_res.original_kept;
    assign o_out.new_kept          = r_res.new_kept;
    assign o_out.child_log_scale_x = r_res.cx;
    assign o_out.child_log_scale_y = r_res.cy;
    assign o_out.child_log_scale_z = r_res.cz;

endmodule

`default_nettype wire

// ----- rtl/gaussian_densify_prune_decider.sv -----
// ----------------------------------------------------------------------------
// gaussian_densify_prune_decider
// Keep/clone/split decision with prune results for one Gaussian per request.
// ----------------------------------------------------------------------------
// path: a request passes through the input register, classify register,
//   queue entry and result register, in that order
// throughput: one request per cycle while the sink takes results; a stalled
//   sink fills the queue and only then holds the input
// reset: clears pipeline valids and queue pointers, loads register defaults
`default_nettype none

module gaussian_densify_prune_decider #(
    parameter int P_QUEUE_DEPTH = gdpd_pkg::QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gdpd_in_if.sink   i_in,
    gdpd_out_if.source o_out,
    gdpd_cfg_if.sink  i_cfg
);

    gdpd_pkg::t_cfg r_cfg;
    logic           w_push_valid, w_push_ready;
    gdpd_pkg::t_cls w_push_data;
    logic           w_pop_valid, w_pop_ready;
    gdpd_pkg::t_cls w_pop_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grad_limit        <= gdpd_pkg::RST_GRAD_LIMIT;
            r_cfg.log_dense_size    <= gdpd_pkg::RST_LOG_DENSE_SIZE;
            r_cfg.log_prune_size    <= gdpd_pkg::RST_LOG_PRUNE_SIZE;
            r_cfg.min_opacity_logit <= gdpd_pkg::RST_MIN_OPACITY_LOGIT;
            r_cfg.max_screen_radius <= gdpd_pkg::RST_MAX_SCREEN_RADIUS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                gdpd_pkg::CFG_GRAD_LIMIT:
                    r_cfg.grad_limit <= i_cfg.data;
                gdpd_pkg::CFG_LOG_DENSE_SIZE:
                    r_cfg.log_dense_size <= i_cfg.data[gdpd_pkg::LOG_W-1:0];
                gdpd_pkg::CFG_LOG_PRUNE_SIZE:
                    r_cfg.log_prune_size <= i_cfg.data[gdpd_pkg::LOG_W-1:0];
                gdpd_pkg::CFG_MIN_OPACITY_LOGIT:
                    r_cfg.min_opacity_logit <= i_cfg.data[gdpd_pkg::LOG_W-1:0];
                gdpd_pkg::CFG_MAX_SCREEN_RADIUS:
                    r_cfg.max_screen_radius <= i_cfg.data[gdpd_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gdpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    gdpd_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    gdpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    // no result may come out of reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // front holds its classified request while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid && !w_push_ready |=> w_push_valid && $stable(w_push_data))
        else $error("front dropped or changed a stalled request");

    // a split always removes the original
    a_split_orig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == gdpd_pkg::ACT_SPLIT |-> !o_out.original_kept)
        else $error("split result keeps the original");

    // keep results carry no appended entries
    a_keep_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.action == gdpd_pkg::ACT_KEEP |->
            o_out.new_kept == 2'd0 && o_out.child_log_scale_x == '0 &&
            o_out.child_log_scale_y == '0 && o_out.child_log_scale_z == '0)
        else $error("keep result with appended entries");
`endif

endmodule

`default_nettype wire
